// ===== design/mpsf_pkg.sv =====
`timescale 1ns / 1ps
// Package: constants, types and built-in pattern table of the multi-pattern substring filter.
package mpsf_pkg;

  localparam int PATTERN_SLOTS     = 16;
  localparam int MAX_PATTERN_BYTES = 32;
  localparam int HIST_DEPTH        = MAX_PATTERN_BYTES - 1;
  localparam int SLOT_W            = 4;
  localparam int POS_W             = 5;
  localparam int LEN_W             = 6;
  localparam int COUNT_W           = 17;
  localparam int ACTIVE_W          = 5;
  localparam int LIMIT_W           = 16;
  localparam int APB_AW            = 3;
  localparam int APB_DW            = 32;

  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 17'd65536;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd15;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd4096;

  // register index, taken from paddr[2]
  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef enum logic [1:0] {
    OP_PAT_BYTE = 2'd0,
    OP_PAT_LEN  = 2'd1,
    OP_TEXT     = 2'd2,
    OP_END      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_PATTERN  = 2'd1,
    VERDICT_TOO_LONG = 2'd2
  } verdict_e;

  typedef logic [MAX_PATTERN_BYTES*8-1:0] row_t;

  // item as it travels down the chain
  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  position;
    logic [7:0]        byte_value;
    logic [LEN_W-1:0]  pattern_length;
    logic              found;
    logic [SLOT_W-1:0] hit_slot;
  } item_t;

  typedef struct packed {
    logic                advance;
    logic                init;
    logic [ACTIVE_W-1:0] active;
  } ctl_t;

  // first character in the most significant used byte
  function automatic row_t builtin_row(input logic [SLOT_W-1:0] s);
    row_t row;
    row = '0;
    case (s)
      4'd0:    row = row_t'("rm -rf /");
      4'd1:    row = row_t'("rm -rf /*");
      4'd2:    row = row_t'("mkfs");
      4'd3:    row = row_t'("dd if=/dev/zero");
      4'd4:    row = row_t'("> /dev/sda");
      4'd5:    row = row_t'("drop table");
      4'd6:    row = row_t'("truncate table");
      4'd7:    row = row_t'("eval(");
      4'd8:    row = row_t'("exec(");
      4'd9:    row = row_t'("system(");
      4'd10:   row = row_t'("popen(");
      4'd11:   row = row_t'("; rm ");
      4'd12:   row = row_t'("| sh");
      4'd13:   row = row_t'(8'h60);
      4'd14:   row = row_t'("$(");
      default: row = '0;
    endcase
    return row;
  endfunction

  function automatic logic [LEN_W-1:0] builtin_len(input logic [SLOT_W-1:0] s);
    logic [LEN_W-1:0] n;
    n = '0;
    case (s)
      4'd0:    n = 6'd8;
      4'd1:    n = 6'd9;
      4'd2:    n = 6'd4;
      4'd3:    n = 6'd15;
      4'd4:    n = 6'd10;
      4'd5:    n = 6'd10;
      4'd6:    n = 6'd14;
      4'd7:    n = 6'd5;
      4'd8:    n = 6'd5;
      4'd9:    n = 6'd7;
      4'd10:   n = 6'd6;
      4'd11:   n = 6'd5;
      4'd12:   n = 6'd4;
      4'd13:   n = 6'd1;
      4'd14:   n = 6'd2;
      default: n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] builtin_byte(input logic [SLOT_W-1:0] s, input int k);
    row_t row;
    int   n;
    row = builtin_row(s);
    n   = int'(builtin_len(s));
    if (k < n) begin
      return row[8*(n-1-k) +: 8];
    end
    return 8'h00;
  endfunction

endpackage

// ===== design/multi_pattern_substring_filter.sv =====
`timescale 1ns / 1ps
// Top level: configuration registers, chain of pattern cells and verdict stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per cycle while
//   in_stall_o is low: pattern byte writes, pattern length writes, text bytes
//   and end of text. Only an end of text item gives a result on the output
//   channel (out_valid_o / out_stall_i): verdict, lowest matching active slot
//   and text length. Every item walks down a chain of 16 slot cells, one cell
//   per cycle while the chain advances, so table writes and text bytes are
//   applied in order. A result passes through the 16 cell registers and then
//   the output register before it shows on out_valid_o. Throughput is one
//   item per cycle while in_stall_o is low. Registers active_patterns (0x0)
//   and length_limit (0x4) sit on the APB port.
//   After reset the block loads the built-in patterns into the cells, with
//   in_stall_o high.
//   While a result waits at the output, items keep flowing; only when a second
//   end of text reaches the tail does the chain freeze and in_stall_o rise
//   until the waiting result is taken.
module multi_pattern_substring_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     op_i,
  input  logic [mpsf_pkg::SLOT_W-1:0]    slot_i,
  input  logic [mpsf_pkg::POS_W-1:0]     position_i,
  input  logic [7:0]                     byte_value_i,
  input  logic [mpsf_pkg::LEN_W-1:0]     pattern_length_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     verdict_o,
  output logic [mpsf_pkg::SLOT_W-1:0]    hit_slot_o,
  output logic [mpsf_pkg::COUNT_W-1:0]   text_length_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpsf_pkg::APB_AW-1:0]    paddr,
  input  logic [mpsf_pkg::APB_DW-1:0]    pwdata,
  output logic [mpsf_pkg::APB_DW-1:0]    prdata,
  output logic                           pready
);

  logic [mpsf_pkg::ACTIVE_W-1:0] active_q, active_d;
  logic [mpsf_pkg::LIMIT_W-1:0]  limit_q, limit_d;
  logic                          init_q;
  logic                          hold;
  logic                          cfg_wr;
  mpsf_pkg::ctl_t                ctl;
  mpsf_pkg::item_t               chain [mpsf_pkg::PATTERN_SLOTS+1];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    active_d = active_q;
    limit_d  = limit_q;
    if (cfg_wr) begin
      case (paddr[2])
        mpsf_pkg::REG_ACTIVE: active_d = pwdata[mpsf_pkg::ACTIVE_W-1:0];
        mpsf_pkg::REG_LIMIT:  limit_d  = pwdata[mpsf_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mpsf_pkg::REG_ACTIVE: prdata = mpsf_pkg::APB_DW'(active_q);
      mpsf_pkg::REG_LIMIT:  prdata = mpsf_pkg::APB_DW'(limit_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= mpsf_pkg::ACTIVE_RESET;
      limit_q  <= mpsf_pkg::LIMIT_RESET;
      init_q   <= 1'b1;
    end else begin
      active_q <= active_d;
      limit_q  <= limit_d;
      init_q   <= 1'b0;
    end
  end

  assign ctl.advance = !init_q && !hold;
  assign ctl.init    = init_q;
  assign ctl.active  = active_q;
  assign in_stall_o  = !ctl.advance;

  assign chain[0].valid          = in_valid_i;
  assign chain[0].op             = mpsf_pkg::op_e'(op_i);
  assign chain[0].slot           = slot_i;
  assign chain[0].position       = position_i;
  assign chain[0].byte_value     = byte_value_i;
  assign chain[0].pattern_length = pattern_length_i;
  assign chain[0].found          = 1'b0;
  assign chain[0].hit_slot       = '0;

  for (genvar s = 0; s < mpsf_pkg::PATTERN_SLOTS; s++) begin : g_cell
    mpsf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .cell_idx_i (mpsf_pkg::SLOT_W'(s)),
      .item_i     (chain[s]),
      .item_o     (chain[s+1])
    );
  end

  mpsf_verdict u_verdict (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .tail_i        (chain[mpsf_pkg::PATTERN_SLOTS]),
    .limit_i       (limit_q),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .verdict_o     (verdict_o),
    .hit_slot_o    (hit_slot_o),
    .text_length_o (text_length_o),
    .hold_o        (hold)
  );

endmodule

// ===== design/mpsf_cell.sv =====
`timescale 1ns / 1ps
// Chain cell: one pattern slot with its own text history, hit flag and end-of-text check.
module mpsf_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpsf_pkg::ctl_t                ctl_i,
  input  logic [mpsf_pkg::SLOT_W-1:0]   cell_idx_i,
  input  mpsf_pkg::item_t               item_i,
  output mpsf_pkg::item_t               item_o
);

  logic [7:0]                  pat_q  [mpsf_pkg::MAX_PATTERN_BYTES];
  logic [7:0]                  pat_d  [mpsf_pkg::MAX_PATTERN_BYTES];
  logic [7:0]                  hist_q [mpsf_pkg::HIST_DEPTH];
  logic [7:0]                  hist_d [mpsf_pkg::HIST_DEPTH];
  logic [7:0]                  win    [mpsf_pkg::MAX_PATTERN_BYTES];
  logic [mpsf_pkg::LEN_W-1:0]  len_q, len_d;
  logic [mpsf_pkg::LEN_W-1:0]  seen_q, seen_d;
  logic [mpsf_pkg::LEN_W-1:0]  seen_inc;
  logic [mpsf_pkg::LEN_W-1:0]  widx;
  logic [mpsf_pkg::MAX_PATTERN_BYTES-1:0] pos_ok;
  logic                        hit_q, hit_d;
  logic                        match;
  logic                        take;
  mpsf_pkg::item_t             item_q, item_d;

  localparam logic [mpsf_pkg::LEN_W-1:0] LenMax = mpsf_pkg::LEN_W'(mpsf_pkg::MAX_PATTERN_BYTES);

  assign take = ctl_i.advance && item_i.valid;

  // window: age 0 is the incoming byte
  always_comb begin
    win[0] = item_i.byte_value;
    for (int a = 1; a < mpsf_pkg::MAX_PATTERN_BYTES; a++) begin
      win[a] = hist_q[a-1];
    end
  end

  assign seen_inc = (seen_q == LenMax) ? seen_q : seen_q + mpsf_pkg::LEN_W'(1);

  // pattern byte k lines up with text age len-1-k
  always_comb begin
    widx = '0;
    for (int k = 0; k < mpsf_pkg::MAX_PATTERN_BYTES; k++) begin
      widx = len_q - mpsf_pkg::LEN_W'(1) - mpsf_pkg::LEN_W'(k);
      if (mpsf_pkg::LEN_W'(k) < len_q) begin
        pos_ok[k] = (pat_q[k] == win[widx[mpsf_pkg::POS_W-1:0]]);
      end else begin
        pos_ok[k] = 1'b1;
      end
    end
  end

  assign match = (len_q != '0) && (seen_inc >= len_q) && (&pos_ok);

  always_comb begin
    pat_d  = pat_q;
    hist_d = hist_q;
    len_d  = len_q;
    seen_d = seen_q;
    hit_d  = hit_q;
    if (ctl_i.init) begin
      for (int k = 0; k < mpsf_pkg::MAX_PATTERN_BYTES; k++) begin
        pat_d[k] = mpsf_pkg::builtin_byte(cell_idx_i, k);
      end
      len_d  = mpsf_pkg::builtin_len(cell_idx_i);
      seen_d = '0;
      hit_d  = 1'b0;
    end else if (take) begin
      case (item_i.op)
        mpsf_pkg::OP_PAT_BYTE: begin
          if (item_i.slot == cell_idx_i) begin
            pat_d[item_i.position] = item_i.byte_value;
          end
        end
        mpsf_pkg::OP_PAT_LEN: begin
          if (item_i.slot == cell_idx_i) begin
            len_d = (item_i.pattern_length > LenMax) ? LenMax : item_i.pattern_length;
          end
        end
        mpsf_pkg::OP_TEXT: begin
          seen_d = seen_inc;
          if (match) begin
            hit_d = 1'b1;
          end
          hist_d[0] = item_i.byte_value;
          for (int i = 1; i < mpsf_pkg::HIST_DEPTH; i++) begin
            hist_d[i] = hist_q[i-1];
          end
        end
        mpsf_pkg::OP_END: begin
          seen_d = '0;
          hit_d  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // end of text: claim the item if this slot is active, has a hit or an empty pattern, and nothing lower has
  always_comb begin
    item_d = item_q;
    if (ctl_i.advance) begin
      item_d = item_i;
      if (item_i.valid && (item_i.op == mpsf_pkg::OP_END) && !item_i.found &&
          (mpsf_pkg::ACTIVE_W'(cell_idx_i) < ctl_i.active) &&
          (hit_q || (len_q == '0))) begin
        item_d.found    = 1'b1;
        item_d.hit_slot = cell_idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
      seen_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      item_q <= item_d;
      seen_q <= seen_d;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q  <= pat_d;
    hist_q <= hist_d;
    len_q  <= len_d;
  end

  assign item_o = item_q;

`ifndef SYNTH
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= LenMax)
    else $error("seen count above pattern size");

  a_hit_from_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hit_q) |-> $past(take && (item_i.op == mpsf_pkg::OP_TEXT)))
    else $error("hit flag set without a text item");

  a_found_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_q.valid && item_q.found |-> item_q.hit_slot <= cell_idx_i)
    else $error("claimed slot lies beyond this cell");

  a_found_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_q.valid && item_q.found |-> item_q.op == mpsf_pkg::OP_END)
    else $error("found mark on an item that is not end of text");
`endif

endmodule

// ===== design/mpsf_verdict.sv =====
`timescale 1ns / 1ps
// Tail stage: text length count, verdict and output register.
module mpsf_verdict (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mpsf_pkg::ctl_t                 ctl_i,
  input  mpsf_pkg::item_t                tail_i,
  input  logic [mpsf_pkg::LIMIT_W-1:0]   limit_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [1:0]                     verdict_o,
  output logic [mpsf_pkg::SLOT_W-1:0]    hit_slot_o,
  output logic [mpsf_pkg::COUNT_W-1:0]   text_length_o,
  output logic                           hold_o
);

  logic [mpsf_pkg::COUNT_W-1:0] count_q, count_d;
  logic [mpsf_pkg::COUNT_W-1:0] text_len_q, text_len_d;
  logic [mpsf_pkg::SLOT_W-1:0]  hit_slot_q, hit_slot_d;
  mpsf_pkg::verdict_e           verdict_q, verdict_d;
  logic                         out_valid_q, out_valid_d;
  logic                         tail_end;
  logic                         take;

  assign tail_end = tail_i.valid && (tail_i.op == mpsf_pkg::OP_END);
  assign take     = ctl_i.advance && tail_i.valid;
  assign hold_o   = tail_end && out_valid_q && out_stall_i;

  always_comb begin
    count_d     = count_q;
    text_len_d  = text_len_q;
    hit_slot_d  = hit_slot_q;
    verdict_d   = verdict_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (take && (tail_i.op == mpsf_pkg::OP_TEXT)) begin
      if (count_q != mpsf_pkg::COUNT_MAX) begin
        count_d = count_q + mpsf_pkg::COUNT_W'(1);
      end
    end
    if (take && (tail_i.op == mpsf_pkg::OP_END)) begin
      count_d     = '0;
      out_valid_d = 1'b1;
      text_len_d  = count_q;
      if (tail_i.found) begin
        verdict_d  = mpsf_pkg::VERDICT_PATTERN;
        hit_slot_d = tail_i.hit_slot;
      end else begin
        hit_slot_d = '0;
        if (count_q > mpsf_pkg::COUNT_W'(limit_i)) begin
          verdict_d = mpsf_pkg::VERDICT_TOO_LONG;
        end else begin
          verdict_d = mpsf_pkg::VERDICT_PASS;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    text_len_q <= text_len_d;
    hit_slot_q <= hit_slot_d;
    verdict_q  <= verdict_d;
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = verdict_q;
  assign hit_slot_o    = hit_slot_q;
  assign text_length_o = text_len_q;

`ifndef SYNTH
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (verdict_q != mpsf_pkg::VERDICT_PATTERN) |-> hit_slot_q == '0)
    else $error("hit slot set without a pattern verdict");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mpsf_pkg::COUNT_MAX)
    else $error("text count beyond saturation");

  a_too_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (verdict_q == mpsf_pkg::VERDICT_TOO_LONG) |->
      text_len_q > mpsf_pkg::COUNT_W'(limit_i))
    else $error("too long verdict within the limit");
`endif

endmodule
